### hw/rtl/hdpzs_pkg.sv
package hdpzs_pkg;

    // reset value of the zone offset register
    localparam logic [4:0] ZONE_RESET = 5'd8;

    // register indexes of the configuration port (paddr[2])
    localparam logic REG_ZONE = 1'b0;

    // characters that delimit the fields
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // saturation limits
    localparam logic [13:0] YEAR_MAX  = 14'd9999;
    localparam logic [6:0]  SMALL_MAX = 7'd99;

    // three-letter names, calendar order
    localparam logic [23:0] DAY_NAMES [0:6] = '{
        24'h4D6F6E, 24'h547565, 24'h576564, 24'h546875,
        24'h467269, 24'h536174, 24'h53756E
    };
    localparam logic [23:0] MONTH_NAMES [0:11] = '{
        24'h4A616E, 24'h466562, 24'h4D6172, 24'h417072,
        24'h4D6179, 24'h4A756E, 24'h4A756C, 24'h417567,
        24'h536570, 24'h4F6374, 24'h4E6F76, 24'h446563
    };

    // character class found by the front end
    typedef enum logic [2:0] {
        CLS_OTHER = 3'd0,
        CLS_DIGIT = 3'd1,
        CLS_COMMA = 3'd2,
        CLS_SPACE = 3'd3,
        CLS_COLON = 3'd4
    } t_cls;

    // one classified byte
    typedef struct packed {
        logic [7:0] ch;
        t_cls       cls;
        logic [3:0] dig;
        logic       last;
    } t_tok;

    // parsed fields of one string, before the zone shift
    typedef struct packed {
        logic [2:0]  wday;
        logic [6:0]  day;
        logic [3:0]  mon;
        logic [13:0] year;
        logic [6:0]  hour;
        logic [6:0]  min;
        logic [6:0]  sec;
    } t_snap;

endpackage

### hw/rtl/hdpzs_front.sv
module hdpzs_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_char_byte,
    input  logic             i_is_last,
    output logic             o_tok_valid,
    output hdpzs_pkg::t_tok  o_tok,
    input  logic             i_tok_full
);
    import hdpzs_pkg::*;

    logic r_valid;
    t_tok r_tok;
    t_tok n_tok;

    // classify the incoming byte
    always_comb begin
        n_tok.ch   = i_char_byte;
        n_tok.last = i_is_last;
        n_tok.dig  = 4'(i_char_byte - CH_ZERO);
        if (i_char_byte >= CH_ZERO && i_char_byte <= CH_NINE) begin
            n_tok.cls = CLS_DIGIT;
        end else if (i_char_byte == CH_COMMA) begin
            n_tok.cls = CLS_COMMA;
        end else if (i_char_byte == CH_SPACE) begin
            n_tok.cls = CLS_SPACE;
        end else if (i_char_byte == CH_COLON) begin
            n_tok.cls = CLS_COLON;
        end else begin
            n_tok.cls = CLS_OTHER;
        end
    end

    // holding register stalls only while the queue is full
    assign o_stall     = r_valid && i_tok_full;
    assign o_tok_valid = r_valid;
    assign o_tok       = r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_tok <= n_tok;
        end
    end

endmodule

### hw/rtl/hdpzs_queue.sv
module hdpzs_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hdpzs_pkg::t_tok  i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output hdpzs_pkg::t_tok  o_data
);
    import hdpzs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    t_tok          r_mem [0:DEPTH-1];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          r_out_valid;
    t_tok          r_out;
    logic          push_ok;
    logic          pop_ok;
    logic          out_load;
    logic          mem_push;
    logic          mem_pop;

    assign o_full   = (r_count == CW'(DEPTH));
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;
    assign push_ok  = i_push && !o_full;
    assign pop_ok   = i_pop && r_out_valid;

    // output register is free, or emptied at this edge
    assign out_load = !r_out_valid || pop_ok;
    // refill from storage first; with storage empty the transfer goes straight through
    assign mem_pop  = out_load && (r_count != '0);
    assign mem_push = push_ok && !(out_load && (r_count == '0));

    // pointers, fill count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr        <= '0;
            r_rd        <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (mem_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + 1'b1;
            end
            if (mem_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
            end
            if (mem_push && !mem_pop) begin
                r_count <= r_count + 1'b1;
            end else if (mem_pop && !mem_push) begin
                r_count <= r_count - 1'b1;
            end
            if (out_load) begin
                r_out_valid <= mem_pop || push_ok;
            end
        end
    end

    // storage and registered read
    always_ff @(posedge i_clk) begin
        if (mem_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (mem_pop) begin
            r_out <= r_mem[r_rd];
        end else if (out_load && push_ok) begin
            r_out <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue push while full");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_push && !mem_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not rise");
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_pop && !mem_push) |=> r_count == $past(r_count) - 1'b1)
        else $error("queue count did not fall");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> r_out_valid && $stable(r_out))
        else $error("queue head changed while waiting");
`endif

endmodule

### hw/rtl/hdpzs_parse.sv
module hdpzs_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tok_valid,
    input  hdpzs_pkg::t_tok  i_tok,
    output logic             o_tok_pop,
    output logic             o_snap_valid,
    output hdpzs_pkg::t_snap o_snap,
    input  logic             i_snap_ready
);
    import hdpzs_pkg::*;

    typedef enum logic [7:0] {
        F_WDAY = 8'b00000001,
        F_DAY  = 8'b00000010,
        F_MON  = 8'b00000100,
        F_YEAR = 8'b00001000,
        F_HOUR = 8'b00010000,
        F_MIN  = 8'b00100000,
        F_SEC  = 8'b01000000,
        F_DONE = 8'b10000000
    } t_field;

    function automatic logic [6:0] small_val(input logic [13:0] a);
        return (a > 14'(SMALL_MAX)) ? SMALL_MAX : a[6:0];
    endfunction

    t_field      r_field, n_field;
    logic [1:0]  r_pos, n_pos;
    logic [13:0] r_acc, n_acc;
    logic        r_stop, n_stop;
    logic [23:0] r_name, n_name;
    logic [2:0]  r_wday, n_wday;
    logic [6:0]  r_day, n_day;
    logic [3:0]  r_mon, n_mon;
    logic [13:0] r_year, n_year;
    logic [6:0]  r_hour, n_hour;
    logic [6:0]  r_min, n_min;
    logic [6:0]  r_sec, n_sec;
    logic        r_snap_valid, n_snap_valid;
    t_snap       r_snap, n_snap;

    logic        pop;
    logic        is_digit;
    logic [16:0] dig_prod;
    logic [13:0] dig_next;
    logic [23:0] name_shift;
    logic [2:0]  wday_hit;
    logic [3:0]  mon_hit;
    logic [2:0]  wday_upd;
    logic [3:0]  mon_upd;

    assign pop       = i_tok_valid && (!r_snap_valid || i_snap_ready);
    assign o_tok_pop = pop;
    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

    // digit accumulate with saturation
    assign is_digit = (i_tok.cls == CLS_DIGIT);
    assign dig_prod = 17'(r_acc) * 17'd10 + 17'(i_tok.dig);
    assign dig_next = (dig_prod > 17'(YEAR_MAX)) ? YEAR_MAX : dig_prod[13:0];

    // name match over the last three bytes, earliest name wins
    assign name_shift = {r_name[15:0], i_tok.ch};

    always_comb begin
        wday_hit = '0;
        for (int i = 6; i >= 0; i--) begin
            if (name_shift == DAY_NAMES[i]) begin
                wday_hit = 3'(i + 1);
            end
        end
        mon_hit = '0;
        for (int i = 11; i >= 0; i--) begin
            if (name_shift == MONTH_NAMES[i]) begin
                mon_hit = 4'(i + 1);
            end
        end
    end

    assign wday_upd = (wday_hit != '0 && (r_wday == '0 || wday_hit < r_wday)) ?
                      wday_hit : r_wday;
    assign mon_upd  = (mon_hit != '0 && (r_mon == '0 || mon_hit < r_mon)) ?
                      mon_hit : r_mon;

    // per-byte field step
    always_comb begin
        n_field      = r_field;
        n_pos        = r_pos;
        n_acc        = r_acc;
        n_stop       = r_stop;
        n_name       = r_name;
        n_wday       = r_wday;
        n_day        = r_day;
        n_mon        = r_mon;
        n_year       = r_year;
        n_hour       = r_hour;
        n_min        = r_min;
        n_sec        = r_sec;
        n_snap_valid = r_snap_valid && !i_snap_ready;
        n_snap       = r_snap;

        if (pop) begin
            case (r_field)
                F_WDAY: begin
                    if (i_tok.cls == CLS_COMMA) begin
                        n_field = F_DAY; n_pos = '0; n_acc = '0; n_name = '0; n_stop = 1'b0;
                    end else begin
                        n_name = name_shift;
                        n_wday = wday_upd;
                    end
                end
                F_DAY: begin
                    if (r_pos == 2'd0) begin
                        n_pos = 2'd1;
                    end else if (r_pos != 2'd3) begin
                        if (!r_stop && is_digit) n_acc = dig_next;
                        else n_stop = 1'b1;
                        n_pos = r_pos + 1'b1;
                    end else begin
                        n_day   = small_val(r_acc);
                        n_field = F_MON; n_pos = '0; n_acc = '0; n_name = '0; n_stop = 1'b0;
                    end
                end
                F_MON: begin
                    if (i_tok.cls == CLS_SPACE) begin
                        n_field = F_YEAR; n_pos = '0; n_acc = '0; n_name = '0; n_stop = 1'b0;
                    end else begin
                        n_name = name_shift;
                        n_mon  = mon_upd;
                    end
                end
                F_YEAR: begin
                    if (i_tok.cls == CLS_SPACE) begin
                        n_year  = r_acc;
                        n_field = F_HOUR; n_pos = '0; n_acc = '0; n_name = '0; n_stop = 1'b0;
                    end else if (!r_stop && is_digit) begin
                        n_acc = dig_next;
                    end else begin
                        n_stop = 1'b1;
                    end
                end
                F_HOUR: begin
                    if (i_tok.cls == CLS_COLON) begin
                        n_hour  = small_val(r_acc);
                        n_field = F_MIN; n_pos = '0; n_acc = '0; n_name = '0; n_stop = 1'b0;
                    end else if (!r_stop && is_digit) begin
                        n_acc = dig_next;
                    end else begin
                        n_stop = 1'b1;
                    end
                end
                F_MIN: begin
                    if (i_tok.cls == CLS_COLON) begin
                        n_min   = small_val(r_acc);
                        n_field = F_SEC; n_pos = '0; n_acc = '0; n_name = '0; n_stop = 1'b0;
                    end else if (!r_stop && is_digit) begin
                        n_acc = dig_next;
                    end else begin
                        n_stop = 1'b1;
                    end
                end
                F_SEC: begin
                    if (i_tok.cls == CLS_SPACE) begin
                        n_sec   = small_val(r_acc);
                        n_field = F_DONE; n_pos = '0; n_acc = '0; n_name = '0; n_stop = 1'b0;
                    end else if (!r_stop && is_digit) begin
                        n_acc = dig_next;
                    end else begin
                        n_stop = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            // last byte: commit the open field, hand over, start over
            if (i_tok.last) begin
                n_snap.wday  = n_wday;
                n_snap.day   = (n_field == F_DAY)  ? small_val(n_acc) : n_day;
                n_snap.mon   = n_mon;
                n_snap.year  = (n_field == F_YEAR) ? n_acc : n_year;
                n_snap.hour  = (n_field == F_HOUR) ? small_val(n_acc) : n_hour;
                n_snap.min   = (n_field == F_MIN)  ? small_val(n_acc) : n_min;
                n_snap.sec   = (n_field == F_SEC)  ? small_val(n_acc) : n_sec;
                n_snap_valid = 1'b1;
                n_field = F_WDAY;
                n_pos   = '0;
                n_acc   = '0;
                n_stop  = 1'b0;
                n_name  = '0;
                n_wday  = '0;
                n_day   = '0;
                n_mon   = '0;
                n_year  = '0;
                n_hour  = '0;
                n_min   = '0;
                n_sec   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field      <= F_WDAY;
            r_pos        <= '0;
            r_acc        <= '0;
            r_stop       <= 1'b0;
            r_name       <= '0;
            r_wday       <= '0;
            r_day        <= '0;
            r_mon        <= '0;
            r_year       <= '0;
            r_hour       <= '0;
            r_min        <= '0;
            r_sec        <= '0;
            r_snap_valid <= 1'b0;
        end else begin
            r_field      <= n_field;
            r_pos        <= n_pos;
            r_acc        <= n_acc;
            r_stop       <= n_stop;
            r_name       <= n_name;
            r_wday       <= n_wday;
            r_day        <= n_day;
            r_mon        <= n_mon;
            r_year       <= n_year;
            r_hour       <= n_hour;
            r_min        <= n_min;
            r_sec        <= n_sec;
            r_snap_valid <= n_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_snap <= n_snap;
    end

endmodule

### hw/rtl/hdpzs_shift.sv
module hdpzs_shift (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [4:0]       i_zone,
    input  logic             i_snap_valid,
    input  hdpzs_pkg::t_snap i_snap,
    output logic             o_snap_ready,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [2:0]       o_weekday,
    output logic [4:0]       o_day_of_month,
    output logic [3:0]       o_month_number,
    output logic [13:0]      o_year_value,
    output logic [4:0]       o_hour_value,
    output logic [6:0]       o_minute_value,
    output logic [6:0]       o_second_value,
    output logic [1:0]       o_name_error
);
    import hdpzs_pkg::*;

    // stage 2: hour sum and reciprocal quotients
    logic        r_v2;
    t_snap       r_s2;
    logic [7:0]  r_sum2;
    logic [6:0]  r_yq2;
    logic [2:0]  r_hk2;
    logic [26:0] yq_prod;
    logic [13:0] hk_prod;
    logic [7:0]  sum;

    // stage 3: hour remainder, carry and leap flag
    logic        r_v3;
    t_snap       r_s3;
    logic [4:0]  r_hmod3;
    logic        r_carry3;
    logic        r_leap3;
    logic [6:0]  yr100;
    logic [7:0]  hmod_w;

    // output stage
    logic        r_ov;
    logic [2:0]  r_wday;
    logic [4:0]  r_day;
    logic [3:0]  r_mon;
    logic [13:0] r_year;
    logic [4:0]  r_hour;
    logic [6:0]  r_min;
    logic [6:0]  r_sec;
    logic [1:0]  r_err;

    logic [6:0]  day1;
    logic [6:0]  day2;
    logic [6:0]  mlen;
    logic [3:0]  mon2;
    logic [13:0] year2;

    logic out_ready;
    logic s3_ready;
    logic s2_ready;

    assign out_ready    = !r_ov || !i_stall;
    assign s3_ready     = !r_v3 || out_ready;
    assign s2_ready     = !r_v2 || s3_ready;
    assign o_snap_ready = s2_ready;

    // year/100 and hour/24 by reciprocal, exact over the value ranges
    assign sum     = 8'(i_snap.hour) + 8'(i_zone);
    assign yq_prod = 27'(i_snap.year) * 27'd5243;
    assign hk_prod = 14'(sum) * 14'd43;

    always_ff @(posedge i_clk) begin
        if (s2_ready && i_snap_valid) begin
            r_s2   <= i_snap;
            r_sum2 <= sum;
            r_yq2  <= yq_prod[25:19];
            r_hk2  <= hk_prod[12:10];
        end
    end

    // remainders
    assign yr100  = 7'(r_s2.year - 14'(r_yq2) * 14'd100);
    assign hmod_w = r_sum2 - 8'(r_hk2) * 8'd24;

    always_ff @(posedge i_clk) begin
        if (s3_ready && r_v2) begin
            r_s3     <= r_s2;
            r_hmod3  <= hmod_w[4:0];
            r_carry3 <= (r_sum2 >= 8'd24);
            r_leap3  <= (r_s2.year[1:0] == 2'd0) && (yr100 != '0 || r_yq2[1:0] == 2'd0);
        end
    end

    // date rollover
    always_comb begin
        case (r_s3.mon)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: mlen = 7'd31;
            4'd2:    mlen = r_leap3 ? 7'd29 : 7'd28;
            default: mlen = 7'd30;
        endcase
        day1  = r_s3.day + 7'(r_carry3);
        day2  = day1;
        mon2  = r_s3.mon;
        year2 = r_s3.year;
        if (r_carry3 && day1 > mlen) begin
            day2 = day1 - mlen;
            if (r_s3.mon >= 4'd12) begin
                mon2 = 4'd1;
                if (r_s3.year < YEAR_MAX) year2 = r_s3.year + 1'b1;
            end else begin
                mon2 = r_s3.mon + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_v3) begin
            r_wday <= r_s3.wday;
            r_day  <= (day2 > 7'd31) ? 5'd31 : day2[4:0];
            r_mon  <= mon2;
            r_year <= year2;
            r_hour <= r_hmod3;
            r_min  <= r_s3.min;
            r_sec  <= r_s3.sec;
            r_err  <= {r_s3.mon == '0, r_s3.wday == '0};
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (s2_ready) r_v2 <= i_snap_valid;
            if (s3_ready) r_v3 <= r_v2;
            if (out_ready) r_ov <= r_v3;
        end
    end

    assign o_valid        = r_ov;
    assign o_weekday      = r_wday;
    assign o_day_of_month = r_day;
    assign o_month_number = r_mon;
    assign o_year_value   = r_year;
    assign o_hour_value   = r_hour;
    assign o_minute_value = r_min;
    assign o_second_value = r_sec;
    assign o_name_error   = r_err;

`ifndef SYNTHESIS
    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> r_hmod3 < 5'd24)
        else $error("shifted hour out of range");
    a_carry_hour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !r_carry3) |-> 8'(r_hmod3) == 8'(r_s3.hour) + 8'(i_zone))
        else $error("hour changed without carry");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> r_ov && $stable(r_year) && $stable(r_day))
        else $error("stalled result changed");
`endif

endmodule

### hw/rtl/http_date_parse_zone_shift_top.sv
// A last byte goes through the front, queue, parser and shift stage 2, stage 3 and
// output registers. Throughput: one byte per cycle unless stalled, set by the field
// parser, which takes one queued byte per cycle; a result leaves the shift pipeline
// every cycle at most. Reset (i_rst_n low, synchronous): zone offset 8, parser at the
// weekday field, queue and pipeline empty; no clearing pass.
module http_date_parse_zone_shift_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte stream
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_byte,
    input  logic        i_is_last,
    // results
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_weekday,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month_number,
    output logic [13:0] o_year_value,
    output logic [4:0]  o_hour_value,
    output logic [6:0]  o_minute_value,
    output logic [6:0]  o_second_value,
    output logic [1:0]  o_name_error,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hdpzs_pkg::*;

    logic       zone_sel;
    logic [4:0] r_zone_hours;
    logic       front_valid;
    t_tok       front_tok;
    logic       q_full;
    logic       q_valid;
    t_tok       q_tok;
    logic       q_pop;
    logic       snap_valid;
    t_snap      snap;
    logic       snap_ready;

    // register file
    assign pready   = 1'b1;
    assign zone_sel = (paddr[2] == REG_ZONE);
    assign prdata   = zone_sel ? {27'd0, r_zone_hours} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_hours <= ZONE_RESET;
        end else if (psel && penable && pwrite && pready && zone_sel) begin
            r_zone_hours <= pwdata[4:0];
        end
    end

    hdpzs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_char_byte (i_char_byte),
        .i_is_last   (i_is_last),
        .o_tok_valid (front_valid),
        .o_tok       (front_tok),
        .i_tok_full  (q_full)
    );

    hdpzs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid && !q_full),
        .i_data  (front_tok),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_tok)
    );

    hdpzs_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tok_valid  (q_valid),
        .i_tok        (q_tok),
        .o_tok_pop    (q_pop),
        .o_snap_valid (snap_valid),
        .o_snap       (snap),
        .i_snap_ready (snap_ready)
    );

    hdpzs_shift u_shift (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_zone         (r_zone_hours),
        .i_snap_valid   (snap_valid),
        .i_snap         (snap),
        .o_snap_ready   (snap_ready),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_weekday      (o_weekday),
        .o_day_of_month (o_day_of_month),
        .o_month_number (o_month_number),
        .o_year_value   (o_year_value),
        .o_hour_value   (o_hour_value),
        .o_minute_value (o_minute_value),
        .o_second_value (o_second_value),
        .o_name_error   (o_name_error)
    );

endmodule

### test/http_date_parse_zone_shift_top_tb.sv
`timescale 1ns / 100ps

module http_date_parse_zone_shift_top_tb;
    import hdpzs_pkg::*;

    // parser position within the date string
    typedef enum bit [2:0] {
        FLD_WDAY,
        FLD_DAY,
        FLD_MON,
        FLD_YEAR,
        FLD_HOUR,
        FLD_MIN,
        FLD_SEC,
        FLD_TAIL
    } t_fld;

    // one parsed and shifted date, as seen on the result port
    typedef struct packed {
        logic [2:0]  wday;
        logic [4:0]  day;
        logic [3:0]  mon;
        logic [13:0] year;
        logic [4:0]  hour;
        logic [6:0]  min;
        logic [6:0]  sec;
        logic [1:0]  nerr;
    } t_date;

    typedef bit [7:0] t_text [$];

    typedef struct {
        string txt;
        bit    typed;
        t_date want;
    } t_dir_row;

    localparam bit [1:0] NERR_WDAY     = 2'b01;
    localparam bit [1:0] NERR_MON      = 2'b10;
    localparam bit [4:0] ZONE_AT_RESET = 5'd8;
    localparam int       LATENCY       = 5;
    localparam int       PHASE_BYTES   = 140;
    localparam int       PHASE_DATES   = 4;
    localparam int       LONG_HOLD     = 200;
    localparam int       BURST_DATES   = 40;

    // a string with no fields, parsed at the reset offset
    localparam t_date BLANK_AT_8 = '{3'd0, 5'd0, 4'd0, 14'd0, 5'd8, 7'd0, 7'd0,
                                     NERR_WDAY | NERR_MON};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_char_byte;
    logic        i_is_last;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_weekday;
    logic [4:0]  o_day_of_month;
    logic [3:0]  o_month_number;
    logic [13:0] o_year_value;
    logic [4:0]  o_hour_value;
    logic [6:0]  o_minute_value;
    logic [6:0]  o_second_value;
    logic [1:0]  o_name_error;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    http_date_parse_zone_shift_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_char_byte    (i_char_byte),
        .i_is_last      (i_is_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_weekday      (o_weekday),
        .o_day_of_month (o_day_of_month),
        .o_month_number (o_month_number),
        .o_year_value   (o_year_value),
        .o_hour_value   (o_hour_value),
        .o_minute_value (o_minute_value),
        .o_second_value (o_second_value),
        .o_name_error   (o_name_error),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    string wday_names [7] = '{"Mon", "Tue", "Wed", "Thu", "Fri", "Sat", "Sun"};
    string mon_names [12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
                              "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};

    // directed strings; typed expectations only where obvious
    t_dir_row directed_rows [16] = '{
        '{"Sun, 16 Oct 2022 14:12:06 GMT", 1'b1,
          '{3'd7, 5'd16, 4'd10, 14'd2022, 5'd22, 7'd12, 7'd6, 2'd0}},
        '{"X", 1'b1, BLANK_AT_8},
        '{"\377", 1'b1, BLANK_AT_8},
        '{",", 1'b1, BLANK_AT_8},
        '{"Wed, 31 Dec 9999 23:59:59 GMT", 1'b0, '0},
        '{"Thu, 28 Feb 2024 20:00:00 GMT", 1'b0, '0},
        '{"Sat, 28 Feb 1900 16:00:00 GMT", 1'b0, '0},
        '{"Tue, 29 Feb 2000 18:30:45 GMT", 1'b0, '0},
        '{"Fri, 30 Apr 2021 23:00:00 GMT", 1'b0, '0},
        '{"mon, 05 Foo 12345 99:99:99 GMT", 1'b0, '0},
        '{"FriMon, 30 SepJan 2021 1", 1'b0, '0},
        '{"Fri, 3", 1'b0, '0},
        '{"Sun, 1x Nov 7 5:6:7", 1'b0, '0},
        '{"Sat, 99 Feb 2023 23:00:00 GMT", 1'b0, '0},
        '{"Mon, 01 Jan 20", 1'b0, '0},
        '{"Sun, 31 Dec 2099 16:00:00 GMT trailing", 1'b0, '0}
    };

    // predictor state
    bit [4:0]  zone_hours;
    t_fld      fld;
    bit [2:0]  tok_pos;
    int        digits;
    bit [23:0] letters;
    bit        digits_done;
    bit [2:0]  wday_held;
    bit [6:0]  day_held;
    bit [3:0]  mon_held;
    bit [13:0] year_held;
    bit [6:0]  hour_held;
    bit [6:0]  min_held;
    bit [6:0]  sec_held;

    t_date expected_dates [$];
    int    mismatches;
    int    phase_dates;
    bit    hold_request;
    bit    hold_burst;

    function automatic void open_field(input t_fld f);
        fld         = f;
        tok_pos     = '0;
        digits      = 0;
        letters     = '0;
        digits_done = 1'b0;
    endfunction

    function automatic void clear_parser();
        open_field(FLD_WDAY);
        wday_held = '0;
        day_held  = '0;
        mon_held  = '0;
        year_held = '0;
        hour_held = '0;
        min_held  = '0;
        sec_held  = '0;
    endfunction

    function automatic bit [23:0] name_code(input string s);
        return {s[0], s[1], s[2]};
    endfunction

    // shift a letter into the token window; earliest calendar name wins
    function automatic int match_name(input bit [7:0] c, input bit month, input int held);
        int        n;
        bit [23:0] code;
        n = month ? 12 : 7;
        letters = {letters[15:0], c};
        if (tok_pos < 3'd7) tok_pos++;
        if (tok_pos >= 3'd3) begin
            for (int i = 0; i < n; i++) begin
                code = month ? name_code(mon_names[i]) : name_code(wday_names[i]);
                if (letters == code && (held == 0 || i + 1 < held)) held = i + 1;
            end
        end
        return held;
    endfunction

    // leading digits only, saturating at 9999
    function automatic void add_digit(input bit [7:0] c);
        if (!digits_done && c >= CH_ZERO && c <= CH_NINE) begin
            digits = digits * 10 + int'(c - CH_ZERO);
            if (digits > 9999) digits = 9999;
        end else begin
            digits_done = 1'b1;
        end
    endfunction

    function automatic bit [6:0] clip_small();
        return (digits > 99) ? 7'd99 : 7'(digits);
    endfunction

    function automatic void store_field();
        case (fld)
            FLD_DAY:  day_held  = clip_small();
            FLD_YEAR: year_held = 14'(digits);
            FLD_HOUR: hour_held = clip_small();
            FLD_MIN:  min_held  = clip_small();
            FLD_SEC:  sec_held  = clip_small();
            default: ;
        endcase
    endfunction

    function automatic bit is_leap(input int y);
        if (y % 4 != 0) return 1'b0;
        if (y % 100 != 0) return 1'b1;
        return (y % 400) == 0;
    endfunction

    function automatic int days_in(input int y, input int m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            2: return is_leap(y) ? 29 : 28;
            default: return 30;
        endcase
    endfunction

    // one byte through the parser; on the last byte, shift and report the date
    function automatic bit advance_parser(input bit [7:0] c, input bit last,
                                          output t_date r);
        int hr;
        int d;
        int m;
        int y;
        int len;
        r = '0;
        case (fld)
            FLD_WDAY: begin
                if (c == CH_COMMA) open_field(FLD_DAY);
                else wday_held = 3'(match_name(c, 1'b0, wday_held));
            end
            FLD_DAY: begin
                if (tok_pos == 3'd0) begin
                    tok_pos = 3'd1;
                end else if (tok_pos <= 3'd2) begin
                    add_digit(c);
                    tok_pos++;
                end else begin
                    store_field();
                    open_field(FLD_MON);
                end
            end
            FLD_MON: begin
                if (c == CH_SPACE) open_field(FLD_YEAR);
                else mon_held = 4'(match_name(c, 1'b1, mon_held));
            end
            FLD_YEAR, FLD_SEC: begin
                if (c == CH_SPACE) begin
                    store_field();
                    open_field(t_fld'(fld + 1));
                end else begin
                    add_digit(c);
                end
            end
            FLD_HOUR, FLD_MIN: begin
                if (c == CH_COLON) begin
                    store_field();
                    open_field(t_fld'(fld + 1));
                end else begin
                    add_digit(c);
                end
            end
            default: ;
        endcase
        if (!last) return 1'b0;
        store_field();

        // zone shift: at most one day forward
        hr = hour_held + zone_hours;
        d  = day_held;
        m  = mon_held;
        y  = year_held;
        if (hr >= 24) begin
            hr = hr % 24;
            d++;
            len = days_in(y, m);
            if (d > len) begin
                d -= len;
                m++;
                if (m > 12) begin
                    m = 1;
                    if (y < 9999) y++;
                end
            end
        end
        if (d > 31) d = 31;

        r.wday = wday_held;
        r.day  = 5'(d);
        r.mon  = 4'(m);
        r.year = 14'(y);
        r.hour = 5'(hr);
        r.min  = min_held;
        r.sec  = sec_held;
        r.nerr = ((wday_held == 0) ? NERR_WDAY : 2'b00) | ((mon_held == 0) ? NERR_MON : 2'b00);
        clear_parser();
        return 1'b1;
    endfunction

    function automatic t_text to_bytes(input string s);
        t_text t;
        for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
        return t;
    endfunction

    function automatic string rand_letters();
        return $sformatf("%c%c%c", $urandom_range(65, 122), $urandom_range(65, 122),
                         $urandom_range(65, 122));
    endfunction

    // odd name tokens: unknown letters, two names, or nothing
    function automatic string odd_name(input bit month);
        int r;
        r = $urandom_range(0, 2);
        if (r == 0) return rand_letters();
        if (r == 1) begin
            if (month) return {mon_names[$urandom_range(0, 11)], mon_names[$urandom_range(0, 11)]};
            return {wday_names[$urandom_range(0, 6)], wday_names[$urandom_range(0, 6)]};
        end
        return "";
    endfunction

    // mostly well-formed dates near month ends, plus noise, cut and broken strings
    function automatic t_text random_date();
        t_text t;
        string wd;
        string mn;
        int    kind;
        int    y;
        int    m;
        int    d;
        int    h;
        kind = $urandom_range(0, 9);
        if (kind == 8) begin
            repeat ($urandom_range(1, 12)) t.push_back(8'($urandom_range(0, 255)));
            return t;
        end
        case ($urandom_range(0, 7))
            0: y = 1900;
            1: y = 2000;
            2: y = 2100;
            3: y = 2024;
            4: y = 9999;
            5: y = $urandom_range(0, 99);
            6: y = $urandom_range(0, 9999);
            default: y = $urandom_range(10000, 99999);
        endcase
        m  = $urandom_range(1, 12);
        wd = ($urandom_range(0, 4) == 0) ? odd_name(1'b0) : wday_names[$urandom_range(0, 6)];
        mn = ($urandom_range(0, 4) == 0) ? odd_name(1'b1) : mon_names[m - 1];
        if ($urandom_range(0, 1) == 1) d = days_in(y, m) - $urandom_range(0, 1);
        else if ($urandom_range(0, 7) == 0) d = $urandom_range(0, 99);
        else d = $urandom_range(1, 31);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: h = $urandom_range(16, 23);
            9: h = $urandom_range(0, 99);
            default: h = $urandom_range(0, 23);
        endcase
        t = to_bytes($sformatf("%s, %02d %s %0d %02d:%02d:%02d GMT", wd, d, mn, y, h,
                               $urandom_range(0, 99), $urandom_range(0, 99)));
        if (kind == 7) t = t[0:$urandom_range(0, t.size() - 1)];
        if (kind == 9) t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
        return t;
    endfunction

    function automatic string show_date(input t_date v);
        return $sformatf("wday %0d %0d-%0d-%0d %0d:%0d:%0d err %0d",
                         v.wday, v.year, v.mon, v.day, v.hour, v.min, v.sec, v.nerr);
    endfunction

    // one byte transfer; the predictor runs once the byte is taken
    task automatic send_byte(input bit [7:0] c, input bit last, input bit no_gaps,
                             output bit made, output t_date r);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_byte <= c;
        i_is_last   <= last;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        made = advance_parser(c, last, r);
    endtask

    task automatic send_text(input t_text txt, input bit typed, input t_date want);
        bit    no_gaps;
        bit    made;
        t_date r;
        no_gaps = hold_burst || ($urandom_range(0, 2) == 0);
        foreach (txt[i]) begin
            send_byte(txt[i], i == txt.size() - 1, no_gaps, made, r);
            if (made) begin
                expected_dates.push_back(typed ? want : r);
                phase_dates++;
            end
        end
    endtask

    // drop valid and wait until the block has nothing left in flight
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_dates.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 16) @(posedge i_clk);
    endtask

    task automatic check_zone(input bit [4:0] want);
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_ZONE, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[4:0] !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("zone register reads %0d, want %0d", rd[4:0], want);
        end
    endtask

    task automatic write_zone(input bit [4:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ZONE, 2'b00};
        pwdata  <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        zone_hours = v;
        check_zone(v);
    endtask

    // result side: random stalls, one long hold on request, compare in order
    initial begin
        int    hold;
        int    mode_left;
        bit    calm;
        t_date got;
        t_date want;
        mode_left = 0;
        calm = 1'b0;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (mode_left == 0) begin
                calm      = ($urandom_range(0, 2) == 0);
                mode_left = 16;
            end
            mode_left--;
            hold = calm ? 0 : $urandom_range(0, 12);
            if (hold_request) begin
                hold         = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            got = {o_weekday, o_day_of_month, o_month_number, o_year_value,
                   o_hour_value, o_minute_value, o_second_value, o_name_error};
            if (expected_dates.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("%0t: unexpected date %s", $time, show_date(got));
            end else begin
                want = expected_dates.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: date mismatch", $time);
                        $display("    got  %s", show_date(got));
                        $display("    want %s", show_date(want));
                    end
                end
            end
        end
    end

    // byte stream, configuration phases and the final verdict
    initial begin
        bit [4:0] zone_plan [5];
        int       phase_bytes;
        t_text    t;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_char_byte <= '0;
        i_is_last   <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        mismatches   = 0;
        phase_dates  = 0;
        hold_request = 1'b0;
        hold_burst   = 1'b0;
        zone_hours   = ZONE_AT_RESET;
        clear_parser();
        zone_plan = '{5'd0, 5'd31, 5'd23, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31))};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_zone(ZONE_AT_RESET);

        foreach (directed_rows[k])
            send_text(to_bytes(directed_rows[k].txt), directed_rows[k].typed,
                      directed_rows[k].want);

        for (int p = 0; p < 5; p++) begin
            settle();
            write_zone(zone_plan[p]);
            phase_bytes = 0;
            phase_dates = 0;
            // fill the block while results are held back
            if (p == 1) begin
                hold_request = 1'b1;
                hold_burst   = 1'b1;
                repeat (BURST_DATES) begin
                    t = '{8'($urandom_range(0, 255))};
                    send_text(t, 1'b0, '0);
                end
                hold_burst = 1'b0;
            end
            while (phase_bytes < PHASE_BYTES || phase_dates < PHASE_DATES) begin
                t = random_date();
                phase_bytes += t.size();
                send_text(t, 1'b0, '0);
            end
        end
        settle();

        if (mismatches == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
